>>> rtl/knapsack_cipher_engine_macros.svh
// Assertion shorthands used by the engine top module.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef KNAPSACK_CIPHER_ENGINE_MACROS_SVH
`define KNAPSACK_CIPHER_ENGINE_MACROS_SVH

// Same-cycle implication.
`define KCE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/kce_pkg.sv
package kce_pkg;

   localparam int KEY_W      = 16;
   localparam int CIPHER_W   = 20;
   localparam int BLOCK_W    = 16;
   localparam int ELEM_IDX_W = 4;
   localparam int KEY_LEN_W  = 5;
   localparam int MOD_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Full product of a 20-bit operand and a 16-bit operand.
   localparam int PROD_W      = CIPHER_W + MOD_W;
   localparam int MUL_STEPS   = MOD_W;
   localparam int RED_STEPS   = PROD_W;
   localparam int STEP_CNT_W  = 6;

   localparam logic [MOD_W-1:0]     MODULUS_RST    = 16'd2;
   localparam logic [MOD_W-1:0]     MULTIPLIER_RST = 16'd1;
   localparam logic [MOD_W-1:0]     INV_MULT_RST   = 16'd1;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST    = 5'd16;

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_ENCRYPT = 2'd1,
      REQ_DECRYPT = 2'd2,
      REQ_NOP     = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS    = 2'd0,
      CSR_MULTIPLIER = 2'd1,
      CSR_INV_MULT   = 2'd2,
      CSR_KEY_LEN    = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [ELEM_IDX_W-1:0] elem_index;
      logic [KEY_W-1:0]      key_value;
      logic [BLOCK_W-1:0]    plain_bits;
      logic [CIPHER_W-1:0]   cipher_value;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_W-1:0]    public_value;
      logic [CIPHER_W-1:0] cipher_out;
      logic [BLOCK_W-1:0]  plain_out;
      logic                decode_error;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_MODMUL,
      ENG_FETCH,
      ENG_STEP,
      ENG_DONE
   } eng_state_type;

   typedef enum logic [1:0] {
      MM_IDLE,
      MM_MUL,
      MM_RED,
      MM_DONE
   } mm_phase_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

>>> rtl/kce_stream_if.sv
interface kce_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/kce_ram.sv
module kce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/kce_modmul.sv
// Bit-serial modular multiplier: shift-add product, then restoring reduction
// one product bit per cycle. A modulus of zero keeps the low product bits.
module kce_modmul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kce_pkg::CIPHER_W-1:0]  op_a,
   input  logic [kce_pkg::MOD_W-1:0]     op_b,
   input  logic [kce_pkg::MOD_W-1:0]     modulus,
   output kce_pkg::mm_status_type        status,
   output logic [kce_pkg::MOD_W-1:0]     result
);
   localparam int AW = kce_pkg::CIPHER_W;
   localparam int MW = kce_pkg::MOD_W;
   localparam int PW = kce_pkg::PROD_W;
   localparam int CW = kce_pkg::STEP_CNT_W;

   kce_pkg::mm_phase_type phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [AW-1:0] opa_ff, opa_in;
   logic [MW-1:0] rem_ff, rem_in;

   logic          mul_last;
   logic          red_last;
   logic [AW:0]   mul_sum;
   logic [PW-1:0] mul_next;
   logic [MW:0]   red_shift;
   logic [MW:0]   red_diff;

   assign mul_last = (cnt_ff == CW'(kce_pkg::MUL_STEPS - 1));
   assign red_last = (cnt_ff == CW'(kce_pkg::RED_STEPS - 1));

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         kce_pkg::MM_IDLE: begin
            if (start) begin
               phase_in = kce_pkg::MM_MUL;
            end
         end
         kce_pkg::MM_MUL: begin
            if (mul_last) begin
               phase_in = (modulus == '0) ? kce_pkg::MM_DONE : kce_pkg::MM_RED;
            end
         end
         kce_pkg::MM_RED: begin
            if (red_last) begin
               phase_in = kce_pkg::MM_DONE;
            end
         end
         kce_pkg::MM_DONE: begin
            phase_in = kce_pkg::MM_IDLE;
         end
         default: begin
            phase_in = kce_pkg::MM_IDLE;
         end
      endcase
   end

   always_comb begin
      status.busy = (phase_ff != kce_pkg::MM_IDLE);
      status.done = (phase_ff == kce_pkg::MM_DONE);
   end

   always_comb begin
      mul_sum   = {1'b0, prod_ff[PW-1:MW]} + (prod_ff[0] ? {1'b0, opa_ff} : '0);
      mul_next  = {mul_sum, prod_ff[MW-1:1]};
      red_shift = {rem_ff, prod_ff[PW-1]};
      red_diff  = red_shift - {1'b0, modulus};

      prod_in = prod_ff;
      opa_in  = opa_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      case (phase_ff)
         kce_pkg::MM_IDLE: begin
            if (start) begin
               prod_in = {AW'(0), op_b};
               opa_in  = op_a;
               rem_in  = '0;
               cnt_in  = '0;
            end
         end
         kce_pkg::MM_MUL: begin
            prod_in = mul_next;
            cnt_in  = mul_last ? '0 : cnt_ff + 1'b1;
            if (mul_last && modulus == '0) begin
               rem_in = mul_next[MW-1:0];
            end
         end
         kce_pkg::MM_RED: begin
            prod_in = {prod_ff[PW-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            rem_in  = (red_shift >= {1'b0, modulus}) ? red_diff[MW-1:0] : red_shift[MW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kce_pkg::MM_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      opa_ff  <= opa_in;
      rem_ff  <= rem_in;
   end

   assign result = rem_ff;
endmodule

>>> rtl/knapsack_cipher_engine.sv
// Channel   Dir  Beat contents
// req_if    in   req_type, elem_index, key_value, plain_bits, cipher_value
// rsp_if    out  public_value, cipher_out, plain_out, decode_error
// csr_*     in   csr_wr_en, csr_index, csr_wdata (write only)
//
// One item is in work at a time. A load and a decrypt first pass through
// the bit-serial modular multiplier (16 multiply steps and 36 reduction
// steps, which a modulus of zero skips); an encrypt and a decrypt then walk
// the n active key elements of the table, with a fetch state on the RAM
// address and a step state on the element.
// Reset is synchronous and active high; the key tables are not cleared.
// A result beat waits in the output register while the next request is taken.
`include "knapsack_cipher_engine_macros.svh"

module knapsack_cipher_engine #(
   parameter int MAX_ELEMS  = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   kce_stream_if.sink                        req_if,
   kce_stream_if.source                      rsp_if,
   input  logic                              csr_wr_en,
   input  logic [kce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kce_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int IDX_W = $clog2(MAX_ELEMS);
   localparam int CNT_W = $clog2(MAX_ELEMS + 1);
   localparam int RAM_W = 2 * VALUE_BITS;
   localparam int MW    = kce_pkg::MOD_W;
   localparam int BW    = kce_pkg::BLOCK_W;
   localparam int CPW   = kce_pkg::CIPHER_W;
   localparam logic [MW-1:0] PV_MASK =
      (VALUE_BITS >= MW) ? {MW{1'b1}} : MW'((64'd1 << VALUE_BITS) - 64'd1);

   // Configuration registers.
   logic [MW-1:0]                 modulus_ff;
   logic [MW-1:0]                 mult_ff;
   logic [MW-1:0]                 inv_mult_ff;
   logic [kce_pkg::KEY_LEN_W-1:0] key_len_ff;

   // Control and the captured request.
   kce_pkg::eng_state_type        state_ff, state_in;
   kce_pkg::req_kind_type         kind_ff, kind_in;
   logic [kce_pkg::ELEM_IDX_W-1:0] elem_idx_ff, elem_idx_in;
   logic [kce_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [BW-1:0]                 plain_ff, plain_in;

   // Walk counter: number of key elements still to visit, highest first.
   logic [CNT_W-1:0]              ctr_ff, ctr_in;

   // Accumulators.
   logic [CPW-1:0]                sum_ff, sum_in;
   logic [BW-1:0]                 block_ff, block_in;
   logic [MW-1:0]                 rem_ff, rem_in;
   logic [MW-1:0]                 pv_ff, pv_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   kce_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                          req_ready;
   logic                          req_fire;
   kce_pkg::req_kind_type         req_kind;
   logic                          slot_free;
   logic [CNT_W-1:0]              n_active;
   logic [IDX_W-1:0]              elem_w;
   logic                          elem_in_block;
   logic                          load_in_range;

   logic                          mm_start;
   logic [CPW-1:0]                mm_op_a;
   logic [MW-1:0]                 mm_op_b;
   kce_pkg::mm_status_type        mm_status;
   logic [MW-1:0]                 mm_result;

   logic                          ram_we;
   logic [RAM_W-1:0]              ram_wdata;
   logic [RAM_W-1:0]              ram_rdata;
   logic [VALUE_BITS-1:0]         ram_priv;
   logic [VALUE_BITS-1:0]         ram_pub;

   assign req_fire  = req_if.valid && req_ready;
   assign req_kind  = kce_pkg::req_kind_type'(req_if.payload.req_type);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // A key length beyond the table depth saturates at the depth.
   assign n_active = (32'(key_len_ff) > MAX_ELEMS) ? CNT_W'(MAX_ELEMS) : CNT_W'(key_len_ff);

   assign elem_w        = IDX_W'(ctr_ff - 1'b1);
   assign elem_in_block = (32'(elem_w) < BW);
   assign load_in_range = (32'(elem_idx_ff) < MAX_ELEMS);

   assign ram_priv = ram_rdata[VALUE_BITS-1:0];
   assign ram_pub  = ram_rdata[RAM_W-1:VALUE_BITS];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= kce_pkg::MODULUS_RST;
         mult_ff     <= kce_pkg::MULTIPLIER_RST;
         inv_mult_ff <= kce_pkg::INV_MULT_RST;
         key_len_ff  <= kce_pkg::KEY_LEN_RST;
      end else if (csr_wr_en) begin
         case (kce_pkg::csr_reg_type'(csr_index))
            kce_pkg::CSR_MODULUS:    modulus_ff  <= csr_wdata[MW-1:0];
            kce_pkg::CSR_MULTIPLIER: mult_ff     <= csr_wdata[MW-1:0];
            kce_pkg::CSR_INV_MULT:   inv_mult_ff <= csr_wdata[MW-1:0];
            kce_pkg::CSR_KEY_LEN:    key_len_ff  <= csr_wdata[kce_pkg::KEY_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Next state. Loads and decrypts first pass through the modular
   // multiplier; encrypts and decrypts then walk the key tables downwards.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kce_pkg::ENG_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  kce_pkg::REQ_LOAD,
                  kce_pkg::REQ_DECRYPT: state_in = kce_pkg::ENG_MODMUL;
                  kce_pkg::REQ_ENCRYPT: begin
                     state_in = (n_active == '0) ? kce_pkg::ENG_DONE : kce_pkg::ENG_FETCH;
                  end
                  default: state_in = kce_pkg::ENG_DONE;
               endcase
            end
         end
         kce_pkg::ENG_MODMUL: begin
            if (mm_status.done) begin
               if (kind_ff == kce_pkg::REQ_DECRYPT && n_active != '0) begin
                  state_in = kce_pkg::ENG_FETCH;
               end else begin
                  state_in = kce_pkg::ENG_DONE;
               end
            end
         end
         kce_pkg::ENG_FETCH: begin
            state_in = kce_pkg::ENG_STEP;
         end
         kce_pkg::ENG_STEP: begin
            state_in = (ctr_ff == CNT_W'(1)) ? kce_pkg::ENG_DONE : kce_pkg::ENG_FETCH;
         end
         kce_pkg::ENG_DONE: begin
            if (slot_free) begin
               state_in = kce_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = kce_pkg::ENG_IDLE;
         end
      endcase
   end

   // Control outputs of the state machine.
   always_comb begin
      req_ready = (state_ff == kce_pkg::ENG_IDLE);
      mm_start  = req_fire &&
                  (req_kind inside {kce_pkg::REQ_LOAD, kce_pkg::REQ_DECRYPT});
      ram_we    = (state_ff == kce_pkg::ENG_MODMUL) && mm_status.done &&
                  (kind_ff == kce_pkg::REQ_LOAD) && load_in_range;
   end

   assign req_if.ready = req_ready;

   // A load multiplies the key element, cut to the element width, by the
   // multiplier; a decrypt multiplies the ciphertext by the inverse multiplier.
   always_comb begin
      if (req_kind == kce_pkg::REQ_LOAD) begin
         mm_op_a = CPW'(req_if.payload.key_value & PV_MASK);
         mm_op_b = mult_ff;
      end else begin
         mm_op_a = req_if.payload.cipher_value;
         mm_op_b = inv_mult_ff;
      end
   end

   // Datapath.
   always_comb begin
      kind_in     = kind_ff;
      elem_idx_in = elem_idx_ff;
      key_in      = key_ff;
      plain_in    = plain_ff;
      ctr_in      = ctr_ff;
      sum_in      = sum_ff;
      block_in    = block_ff;
      rem_in      = rem_ff;
      pv_in       = pv_ff;
      case (state_ff)
         kce_pkg::ENG_IDLE: begin
            if (req_fire) begin
               kind_in     = req_kind;
               elem_idx_in = req_if.payload.elem_index;
               key_in      = req_if.payload.key_value;
               plain_in    = req_if.payload.plain_bits;
               ctr_in      = n_active;
               sum_in      = '0;
               block_in    = '0;
               rem_in      = '0;
               pv_in       = '0;
            end
         end
         kce_pkg::ENG_MODMUL: begin
            if (mm_status.done) begin
               pv_in  = mm_result & PV_MASK;
               rem_in = mm_result;
               ctr_in = n_active;
            end
         end
         kce_pkg::ENG_STEP: begin
            ctr_in = ctr_ff - 1'b1;
            if (kind_ff == kce_pkg::REQ_ENCRYPT) begin
               if (elem_in_block && plain_ff[4'(elem_w)]) begin
                  sum_in = sum_ff + CPW'(ram_pub);
               end
            end else begin
               // Greedy step: take the element whenever it still fits.
               if (33'(rem_ff) >= 33'(ram_priv)) begin
                  rem_in = rem_ff - MW'(ram_priv);
                  if (elem_in_block) begin
                     block_in[4'(elem_w)] = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_wdata = {VALUE_BITS'(pv_in), VALUE_BITS'(key_ff)};

   // Result assembly; fields that do not belong to the item's kind are zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == kce_pkg::ENG_DONE && slot_free) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.public_value  = (kind_ff == kce_pkg::REQ_LOAD) ? pv_ff : '0;
         rsp_data_in.cipher_out    = (kind_ff == kce_pkg::REQ_ENCRYPT) ? sum_ff : '0;
         rsp_data_in.plain_out     = (kind_ff == kce_pkg::REQ_DECRYPT) ? block_ff : '0;
         rsp_data_in.decode_error  = (kind_ff == kce_pkg::REQ_DECRYPT) && (rem_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kce_pkg::ENG_IDLE;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      elem_idx_ff <= elem_idx_in;
      key_ff      <= key_in;
      plain_ff    <= plain_in;
      sum_ff      <= sum_in;
      block_ff    <= block_in;
      rem_ff      <= rem_in;
      pv_ff       <= pv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   kce_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_op_a),
      .op_b    (mm_op_b),
      .modulus (modulus_ff),
      .status  (mm_status),
      .result  (mm_result)
   );

   // Private element in the low half of each word, public element above it.
   kce_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_ELEMS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(elem_idx_ff)),
      .wr_data (ram_wdata),
      .rd_addr (elem_w),
      .rd_data (ram_rdata)
   );

   `KCE_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != kce_pkg::ENG_IDLE, "accepted beat left the engine idle")
   `KCE_ASSERT_IMPLY(a_ram_write_on_load, ram_we, (kind_ff == kce_pkg::REQ_LOAD) && (state_ff == kce_pkg::ENG_MODMUL), "key table written outside a load")
   `KCE_ASSERT_IMPLY(a_walk_count_live, (state_ff == kce_pkg::ENG_FETCH) || (state_ff == kce_pkg::ENG_STEP), ctr_ff != '0, "table walk with no element left")
   `KCE_ASSERT_IMPLY(a_mm_start_when_free, mm_start, !mm_status.busy, "multiplier started while busy")
   `KCE_ASSERT_IMPLY(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == kce_pkg::ENG_DONE), "result beat raised outside the done state")
endmodule
